// ===== src/sdf_pkg.sv =====
// sdf_pkg: shared types and constants of the spring-damper force pipeline
// no dependencies; used by every file under src
package sdf_pkg;

  localparam int unsigned LenW   = 33;        // separation length, unsigned Q17.16
  localparam int unsigned SqW    = 2 * LenW;  // exact square sum
  localparam int unsigned UW     = 31;        // direction magnitude, Q1.30
  localparam int unsigned FrontSt = 3;        // difference, square, sum
  localparam int unsigned BackSt  = 6;        // rate, spring, force stages
  localparam int unsigned PipeLat = FrontSt + LenW + UW + BackSt;

  typedef enum logic [1:0] {
    RegStiffness  = 2'd0,
    RegDamping    = 2'd1,
    RegRestLength = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_a_z;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [31:0] vel_b_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               zero_length;
    logic               saturated;
  } out_t;

  // geometry that rides along the square root
  typedef struct packed {
    logic [2:0][31:0] rel_mag;
    logic [2:0]       rel_neg;
    logic [2:0][32:0] vrel;
  } geo_t;

  // what rides along the direction dividers
  typedef struct packed {
    logic [2:0][32:0]  vrel;
    logic [2:0]        rel_neg;
    logic [LenW-1:0]   len;
    logic              zero;
  } div_side_t;

endpackage

// ===== src/sdf_sqrt.sv =====
// sdf_sqrt: pipelined floor square root, one result bit per stage
// depends on sdf_pkg (widths, geo_t)
module sdf_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [sdf_pkg::SqW-1:0]     rad_i,
  input  sdf_pkg::geo_t               side_i,
  output logic                        valid_o,
  output logic [sdf_pkg::LenW-1:0]    root_o,
  output sdf_pkg::geo_t               side_o
);
  localparam int unsigned N    = sdf_pkg::LenW;
  localparam int unsigned RemW = N + 2;

  logic                vld_q  [1:N];
  logic [RemW-1:0]     rem_q  [1:N];
  logic [N-1:0]        root_q [1:N];
  logic [2*N-1:0]      rad_q  [1:N];
  sdf_pkg::geo_t       side_q [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic            vin;
    logic [RemW-1:0] rin;
    logic [N-1:0]    root_in;
    logic [2*N-1:0]  rad_in;
    sdf_pkg::geo_t   sin;
    logic [RemW-1:0] sh, trial, rem_d;
    logic [N-1:0]    root_d;

    if (k == 0) begin : g_first
      assign vin     = valid_i;
      assign rin     = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign sin     = side_i;
    end else begin : g_next
      assign vin     = vld_q[k];
      assign rin     = rem_q[k];
      assign root_in = root_q[k];
      assign rad_in  = rad_q[k];
      assign sin     = side_q[k];
    end

    // trial subtract of (root << 2) | 1 against the next radicand pair
    always_comb begin
      sh    = {rin[RemW-3:0], rad_in[2*N-1 -: 2]};
      trial = {root_in, 2'b01};
      if (sh >= trial) begin
        rem_d  = sh - trial;
        root_d = {root_in[N-2:0], 1'b1};
      end else begin
        rem_d  = sh;
        root_d = {root_in[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= rem_d;
      root_q[k+1] <= root_d;
      rad_q[k+1]  <= {rad_in[2*N-3:0], 2'b00};
      side_q[k+1] <= sin;
    end
  end

  assign valid_o = vld_q[N];
  assign root_o  = root_q[N];
  assign side_o  = side_q[N];

endmodule

// ===== src/sdf_div.sv =====
// sdf_div: three-lane pipelined restoring divider forming the unit direction
// depends on sdf_pkg (widths, geo_t, div_side_t)
module sdf_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [sdf_pkg::LenW-1:0]       len_i,
  input  sdf_pkg::geo_t                  side_i,
  output logic                           valid_o,
  output logic [2:0][sdf_pkg::UW-1:0]    u_mag_o,
  output logic [2:0]                     u_neg_o,
  output sdf_pkg::div_side_t             side_o
);
  localparam int unsigned M  = sdf_pkg::UW;
  localparam int unsigned LW = sdf_pkg::LenW;

  logic                  vld_q  [1:M];
  logic [2:0][LW-1:0]    rem_q  [1:M];
  logic [2:0][M-1:0]     quo_q  [1:M];
  logic [2:0][M-1:0]     low_q  [1:M];
  sdf_pkg::div_side_t    side_q [1:M];

  sdf_pkg::div_side_t side_in;

  always_comb begin
    side_in.vrel    = side_i.vrel;
    side_in.rel_neg = side_i.rel_neg;
    side_in.len     = len_i;
    side_in.zero    = (len_i == '0);
  end

  for (genvar k = 0; k < M; k++) begin : g_step
    logic                vin;
    logic [2:0][LW-1:0]  rin;
    logic [2:0][M-1:0]   qin, lin;
    sdf_pkg::div_side_t  sin;
    logic [LW:0]         sh;
    logic [2:0][LW-1:0]  rem_d;
    logic [2:0][M-1:0]   quo_d, low_d;

    if (k == 0) begin : g_first
      // |rel| <= len, so |rel| >> 1 already sits below the divisor
      always_comb begin
        vin = valid_i;
        sin = side_in;
        for (int i = 0; i < 3; i++) begin
          rin[i] = {2'b00, side_i.rel_mag[i][31:1]};
          qin[i] = '0;
          lin[i] = {side_i.rel_mag[i][0], {(M-1){1'b0}}};
        end
      end
    end else begin : g_next
      assign vin = vld_q[k];
      assign rin = rem_q[k];
      assign qin = quo_q[k];
      assign lin = low_q[k];
      assign sin = side_q[k];
    end

    always_comb begin
      sh = '0;
      for (int i = 0; i < 3; i++) begin
        sh       = {rin[i], lin[i][M-1]};
        low_d[i] = {lin[i][M-2:0], 1'b0};
        if (sh >= {1'b0, sin.len}) begin
          rem_d[i] = LW'(sh - {1'b0, sin.len});
          quo_d[i] = {qin[i][M-2:0], 1'b1};
        end else begin
          rem_d[i] = sh[LW-1:0];
          quo_d[i] = {qin[i][M-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= rem_d;
      quo_q[k+1]  <= quo_d;
      low_q[k+1]  <= low_d;
      side_q[k+1] <= sin;
    end
  end

  // coincident points take the x axis as direction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side_q[M].zero) begin
        u_mag_o[i] = (i == 0) ? M'(1) << (M - 1) : '0;
        u_neg_o[i] = 1'b0;
      end else begin
        u_mag_o[i] = quo_q[M][i];
        u_neg_o[i] = side_q[M].rel_neg[i];
      end
    end
  end

  assign valid_o = vld_q[M];
  assign side_o  = side_q[M];

endmodule

// ===== src/sdf_force.sv =====
// sdf_force: rate projection, spring-damper scalar and saturating force, six stages
// depends on sdf_pkg (widths, div_side_t, out_t)
module sdf_force (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [2:0][sdf_pkg::UW-1:0]   u_mag_i,
  input  logic [2:0]                    u_neg_i,
  input  sdf_pkg::div_side_t            side_i,
  input  logic [31:0]                   stiffness_i,
  input  logic [31:0]                   damping_i,
  input  logic [30:0]                   rest_length_i,
  output logic                          done_o,
  output sdf_pkg::out_t                 res_o
);
  localparam int unsigned UW = sdf_pkg::UW;

  // stage 1: velocity products and stretch
  logic              v1_q;
  logic [2:0][62:0]  pr1_q;
  logic [2:0]        pn1_q;
  logic [33:0]       d1_q;
  logic [2:0][UW-1:0] u1_q;
  logic [2:0]        un1_q;
  logic              z1_q;

  logic [2:0][62:0]  pr1_d;
  logic [2:0]        pn1_d;
  logic [31:0]       vmag;

  always_comb begin
    vmag = '0;
    for (int i = 0; i < 3; i++) begin
      vmag     = side_i.vrel[i][32] ? 32'(33'd0 - side_i.vrel[i]) : side_i.vrel[i][31:0];
      pr1_d[i] = 63'(vmag) * 63'(u_mag_i[i]);
      pn1_d[i] = side_i.vrel[i][32] ^ u_neg_i[i];
    end
  end

  // stage 2: rate sum
  logic              v2_q;
  logic [35:0]       rate2_q;
  logic [33:0]       d2_q;
  logic [2:0][UW-1:0] u2_q;
  logic [2:0]        un2_q;
  logic              z2_q;

  logic [35:0]       rate2_d;
  logic [35:0]       term;

  always_comb begin
    rate2_d = '0;
    term    = '0;
    for (int i = 0; i < 3; i++) begin
      term    = {3'b000, pr1_q[i][62:30]};
      rate2_d = pn1_q[i] ? rate2_d - term : rate2_d + term;
    end
  end

  // stage 3: stiffness and damping products
  logic              v3_q;
  logic [64:0]       t1_q;
  logic [66:0]       t2_q;
  logic              t1n_q, t2n_q;
  logic [2:0][UW-1:0] u3_q;
  logic [2:0]        un3_q;
  logic              z3_q;

  logic [32:0]       dmag;
  logic [34:0]       rmag;

  always_comb begin
    dmag = d2_q[33] ? 33'(34'd0 - d2_q) : d2_q[32:0];
    rmag = rate2_q[35] ? 35'(36'd0 - rate2_q) : rate2_q[34:0];
  end

  // stage 4: scalar s = -(k*d + c*rate) as sign and magnitude
  logic              v4_q;
  logic [67:0]       smag4_q;
  logic              sn4_q;
  logic [2:0][UW-1:0] u4_q;
  logic [2:0]        un4_q;
  logic              z4_q;

  logic [68:0]       a4, b4, s4;

  always_comb begin
    a4 = t1n_q ? 69'd0 - 69'(t1_q) : 69'(t1_q);
    b4 = t2n_q ? 69'd0 - 69'(t2_q) : 69'(t2_q);
    s4 = 69'd0 - (a4 + b4);
  end

  // stage 5: split products of the scalar and each direction component
  logic              v5_q;
  logic [2:0][64:0]  lo5_q, hi5_q;
  logic [2:0]        fn5_q;
  logic              z5_q;

  // stage 6: combine, truncate and clamp
  logic [98:0]       p6;
  logic [52:0]       q6, lim6;
  logic [31:0]       m6;
  logic [2:0][31:0]  f6;
  logic              sat6;

  always_comb begin
    p6   = '0;
    q6   = '0;
    lim6 = '0;
    m6   = '0;
    sat6 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p6   = {hi5_q[i], 34'd0} + 99'(lo5_q[i]);
      q6   = p6[98:46];
      lim6 = fn5_q[i] ? 53'h0_8000_0000 : 53'h0_7FFF_FFFF;
      if (q6 > lim6) begin
        m6   = lim6[31:0];
        sat6 = 1'b1;
      end else begin
        m6 = q6[31:0];
      end
      f6[i] = fn5_q[i] ? 32'd0 - m6 : m6;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      done_o <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pr1_q <= pr1_d;
    pn1_q <= pn1_d;
    d1_q  <= {1'b0, side_i.len} - {3'b000, rest_length_i};
    u1_q  <= u_mag_i;
    un1_q <= u_neg_i;
    z1_q  <= side_i.zero;

    rate2_q <= rate2_d;
    d2_q    <= d1_q;
    u2_q    <= u1_q;
    un2_q   <= un1_q;
    z2_q    <= z1_q;

    t1_q  <= 65'(stiffness_i) * 65'(dmag);
    t2_q  <= 67'(damping_i) * 67'(rmag);
    t1n_q <= d2_q[33];
    t2n_q <= rate2_q[35];
    u3_q  <= u2_q;
    un3_q <= un2_q;
    z3_q  <= z2_q;

    smag4_q <= s4[68] ? 68'(69'd0 - s4) : s4[67:0];
    sn4_q   <= s4[68];
    u4_q    <= u3_q;
    un4_q   <= un3_q;
    z4_q    <= z3_q;

    for (int i = 0; i < 3; i++) begin
      lo5_q[i] <= 65'(smag4_q[33:0]) * 65'(u4_q[i]);
      hi5_q[i] <= 65'(smag4_q[67:34]) * 65'(u4_q[i]);
      fn5_q[i] <= sn4_q ^ un4_q[i];
    end
    z5_q <= z4_q;

    res_o.force_x     <= f6[0];
    res_o.force_y     <= f6[1];
    res_o.force_z     <= f6[2];
    res_o.zero_length <= z5_q;
    res_o.saturated   <= sat6;
  end

endmodule

// ===== src/spring_damper_force.sv =====
// spring_damper_force: top level of the Q16.16 spring-damper force pipeline
// depends on sdf_pkg, sdf_sqrt, sdf_div and sdf_force
//
// A beat is accepted on every cycle where start is high; busy stays low, since
// the pipeline takes a new pair of points each cycle. Each beat produces one result,
// shown for a single cycle with done_o high, once it has passed 3 front stages
// (differences, squares, square sum), 33 square root stages (one root bit each),
// 31 divider stages (one direction bit each, three lanes side by side) and 6 back
// stages (rate, stretch, spring-damper scalar, force products, clamp). Results come
// out in input order and cannot be held off, so the receiver must take done_o beats
// as they arrive. The force is the one on point A; point B gets its negation.
// Coincident points use direction (1,0,0) and raise zero_length; saturated flags
// any clamped force component. Registers are written through the cfg channel
// (always ready) and should only change while no beat is in flight.
module spring_damper_force (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  sdf_pkg::in_t         in_i,
  output logic                 done_o,
  output sdf_pkg::out_t        res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  // configuration registers
  logic [31:0] stiffness_q, damping_q;
  logic [30:0] rest_length_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q   <= '0;
      damping_q     <= '0;
      rest_length_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sdf_pkg::cfg_reg_e'(cfg_idx_i))
        sdf_pkg::RegStiffness:  stiffness_q   <= cfg_data_i;
        sdf_pkg::RegDamping:    damping_q     <= cfg_data_i;
        sdf_pkg::RegRestLength: rest_length_q <= cfg_data_i[30:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // a beat enters every cycle, so never busy
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // unpack the point positions and velocities into per-axis arrays
  logic [2:0][31:0] pa, pb, va, vb;

  always_comb begin
    pa[0] = in_i.pos_a_x;  pa[1] = in_i.pos_a_y;  pa[2] = in_i.pos_a_z;
    pb[0] = in_i.pos_b_x;  pb[1] = in_i.pos_b_y;  pb[2] = in_i.pos_b_z;
    va[0] = in_i.vel_a_x;  va[1] = in_i.vel_a_y;  va[2] = in_i.vel_a_z;
    vb[0] = in_i.vel_b_x;  vb[1] = in_i.vel_b_y;  vb[2] = in_i.vel_b_z;
  end

  // front stage 1: relative position and velocity, 33 bit exact
  sdf_pkg::geo_t geo1_d, geo1_q, geo2_q, geo3_q;
  logic [32:0]   rel;

  always_comb begin
    rel = '0;
    for (int i = 0; i < 3; i++) begin
      rel               = {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
      geo1_d.rel_neg[i] = rel[32];
      geo1_d.rel_mag[i] = rel[32] ? 32'(33'd0 - rel) : rel[31:0];
      geo1_d.vrel[i]    = {va[i][31], va[i]} - {vb[i][31], vb[i]};
    end
  end

  // front stage 2: squared components, stage 3: square sum
  logic [2:0][63:0]           sq2_q;
  logic [sdf_pkg::SqW-1:0]    sum3_q;
  logic                       v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    geo1_q <= geo1_d;
    for (int i = 0; i < 3; i++) begin
      sq2_q[i] <= 64'(geo1_q.rel_mag[i]) * 64'(geo1_q.rel_mag[i]);
    end
    geo2_q <= geo1_q;
    sum3_q <= sdf_pkg::SqW'(sq2_q[0]) + sdf_pkg::SqW'(sq2_q[1])
            + sdf_pkg::SqW'(sq2_q[2]);
    geo3_q <= geo2_q;
  end

  // separation length
  logic                       sq_valid;
  logic [sdf_pkg::LenW-1:0]   len;
  sdf_pkg::geo_t              sq_side;

  sdf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .rad_i   (sum3_q),
    .side_i  (geo3_q),
    .valid_o (sq_valid),
    .root_o  (len),
    .side_o  (sq_side)
  );

  // unit direction, Q1.30 sign and magnitude
  logic                          dv_valid;
  logic [2:0][sdf_pkg::UW-1:0]   u_mag;
  logic [2:0]                    u_neg;
  sdf_pkg::div_side_t            dv_side;

  sdf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .len_i   (len),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .u_mag_o (u_mag),
    .u_neg_o (u_neg),
    .side_o  (dv_side)
  );

  // rate, spring-damper scalar and clamped force
  sdf_force u_force (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (dv_valid),
    .u_mag_i       (u_mag),
    .u_neg_i       (u_neg),
    .side_i        (dv_side),
    .stiffness_i   (stiffness_q),
    .damping_i     (damping_q),
    .rest_length_i (rest_length_q),
    .done_o        (done_o),
    .res_o         (res_o)
  );

`ifndef SYNTHESIS
  // every result traces back to a beat taken a fixed latency earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, sdf_pkg::PipeLat))
    else $error("result without a matching input beat");

  // coincident points point along x only
  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.zero_length |-> res_o.force_y == 32'sd0 && res_o.force_z == 32'sd0)
    else $error("zero-length result has a y or z force");

  // a clamped result has a component at a range end
  a_sat_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.saturated |->
      res_o.force_x == 32'h7FFF_FFFF || res_o.force_x == 32'h8000_0000 ||
      res_o.force_y == 32'h7FFF_FFFF || res_o.force_y == 32'h8000_0000 ||
      res_o.force_z == 32'h7FFF_FFFF || res_o.force_z == 32'h8000_0000)
    else $error("saturated flag without a clamped component");
`endif

endmodule
